FILE: design/msrt_pkg.sv
// Shared types, constants and codes for the masked scatter-reduce table.
// Used by every module of the block; depends on nothing.
package msrt_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);

  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned TSIZE_W    = 11;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_MUL     = 3'd2,
    OP_MIN     = 3'd3,
    OP_MAX     = 3'd4,
    OP_STORE   = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_OOR     = 2'd2,
    ST_READ    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE    = 2'd0,
    REG_IS_SIGNED  = 2'd1,
    REG_TABLE_SIZE = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_EXEC  = 2'd2
  } fsm_e;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  mask;
  } entry_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic              address_masked;
    logic [VAL_W-1:0]  value;
    logic              value_masked;
    logic              in_range;
  } item_t;

endpackage

FILE: design/masked_scatter_reduce_table_unit.sv
// Masked scatter-reduce table: top level with control, forwarding and output.
// Depends on msrt_pkg, msrt_table_mem and msrt_alu.
// An accepted item is held in a register until the output register can take
// its result. Throughput: one item per cycle while the result side keeps up;
// the table memory is read at accept and written when the item completes.
// Reset: config returns to defaults, then a clearing pass over all DEPTH (1024)
// entries zeroes the table, during which no item is accepted.
module masked_scatter_reduce_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: address[9:0], address_masked[10], value[42:11], value_masked[43], zero pad
  input  logic [msrt_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: kind[0]
  input  logic                              s_axis_tuser_i,
  // master side
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: entry_value[31:0], entry_mask[32], zero pad
  output logic [msrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                        m_axis_tuser_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [msrt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msrt_pkg::CFG_W-1:0]        cfg_data_i
);
  import msrt_pkg::*;

  // configuration
  op_e                 op_mode_q;
  logic                is_signed_q;
  logic [TSIZE_W-1:0]  table_size_q;

  // control
  fsm_e                state_q, state_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic                clr_last;
  logic                accept;
  logic                finish;

  // item in flight
  item_t               item_q;
  item_t               item_in;

  // forwarding of the last written entry
  logic                fwd_q;
  entry_t              fwd_data_q;

  // memory
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  logic [AW-1:0]       mem_raddr;
  entry_t              mem_rdata;

  // update datapath
  entry_t              old_entry;
  entry_t              new_entry;
  logic [DATA_WIDTH-1:0] alu_result;
  status_e             status;
  logic                upd_we;

  // output register
  logic                m_valid_q;
  status_e             m_status_q;
  logic [VAL_W-1:0]    m_value_q;
  logic                m_mask_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q    <= OP_ADD;
      is_signed_q  <= 1'b1;
      table_size_q <= TSIZE_W'(1024);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OP_MODE:    op_mode_q    <= op_e'(cfg_data_i[2:0]);
        REG_IS_SIGNED:  is_signed_q  <= cfg_data_i[0];
        REG_TABLE_SIZE: table_size_q <= cfg_data_i[TSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input unpack ----------------
  always_comb begin
    item_in.kind           = s_axis_tuser_i;
    item_in.address        = s_axis_tdata_i[9:0];
    item_in.address_masked = s_axis_tdata_i[10];
    item_in.value          = s_axis_tdata_i[42:11];
    item_in.value_masked   = s_axis_tdata_i[43];
    item_in.in_range       = ({1'b0, s_axis_tdata_i[9:0]} < table_size_q) &&
                             (32'(s_axis_tdata_i[9:0]) < DEPTH);
  end

  // ---------------- state machine ----------------
  assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  // the item in flight completes once the output register can take it
  assign finish   = (state_q == FSM_EXEC) && (!m_valid_q || m_axis_tready_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_CLEAR: if (clr_last) state_d = FSM_IDLE;
      FSM_IDLE:  if (accept)   state_d = FSM_EXEC;
      FSM_EXEC:  if (finish)   state_d = accept ? FSM_EXEC : FSM_IDLE;
      default:   state_d = FSM_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    clr_cnt_d       = clr_cnt_q;
    unique case (state_q)
      FSM_CLEAR: clr_cnt_d       = clr_cnt_q + AW'(1);
      FSM_IDLE:  s_axis_tready_o = 1'b1;
      FSM_EXEC:  s_axis_tready_o = finish;
      default:   s_axis_tready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_CLEAR;
      clr_cnt_q <= '0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      // forward when the next item hits the entry written this cycle
      if (accept) begin
        fwd_q <= upd_we && finish && (item_in.address == item_q.address);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= item_in;
      fwd_data_q <= new_entry;
    end
  end

  // ---------------- table memory ----------------
  assign mem_raddr = AW'(item_in.address);

  always_comb begin
    if (state_q == FSM_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = upd_we && finish;
      mem_waddr = AW'(item_q.address);
      mem_wdata = new_entry;
    end
  end

  msrt_table_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------- update ----------------
  assign old_entry = fwd_q ? fwd_data_q : mem_rdata;

  msrt_alu u_alu (
    .op_i        (op_mode_q),
    .is_signed_i (is_signed_q),
    .old_i       (old_entry.value),
    .operand_i   (DATA_WIDTH'(item_q.value)),
    .result_o    (alu_result)
  );

  always_comb begin
    status    = ST_APPLIED;
    upd_we    = 1'b0;
    new_entry = old_entry;
    if (item_q.kind == KIND_READ) begin
      status = item_q.in_range ? ST_READ : ST_OOR;
    end else if (op_mode_q == OP_STORE) begin
      if (item_q.address_masked) begin
        status = ST_SKIPPED;
      end else if (!item_q.in_range) begin
        status = ST_OOR;
      end else begin
        upd_we = 1'b1;
        if (item_q.value_masked) begin
          new_entry.mask = 1'b1;
        end else begin
          new_entry.value = DATA_WIDTH'(item_q.value);
          new_entry.mask  = 1'b0;
        end
      end
    end else begin
      if (item_q.address_masked || item_q.value_masked) begin
        status = ST_SKIPPED;
      end else if (!item_q.in_range) begin
        status = ST_OOR;
      end else if (old_entry.mask) begin
        status = ST_SKIPPED;
      end else begin
        upd_we          = 1'b1;
        new_entry.value = alu_result;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_status_q <= status;
      m_value_q  <= item_q.in_range ? VAL_W'(new_entry.value) : '0;
      m_mask_q   <= item_q.in_range ? new_entry.mask : 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-VAL_W-1){1'b0}}, m_mask_q, m_value_q};

endmodule

FILE: design/msrt_table_mem.sv
// Element and mask storage: one write port, one read port, registered read.
// Depends on msrt_pkg for the entry type and depth.
module msrt_table_mem (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [msrt_pkg::AW-1:0] waddr_i,
  input  msrt_pkg::entry_t   wdata_i,
  input  logic               re_i,
  input  logic [msrt_pkg::AW-1:0] raddr_i,
  output msrt_pkg::entry_t   rdata_o
);
  import msrt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/msrt_alu.sv
// Reduce unit: wrapping add, sub, multiply and signed or unsigned min/max.
// Depends on msrt_pkg for the op codes and element width.
module msrt_alu (
  input  msrt_pkg::op_e                     op_i,
  input  logic                              is_signed_i,
  input  logic [msrt_pkg::DATA_WIDTH-1:0]   old_i,
  input  logic [msrt_pkg::DATA_WIDTH-1:0]   operand_i,
  output logic [msrt_pkg::DATA_WIDTH-1:0]   result_o
);
  import msrt_pkg::*;

  logic [DATA_WIDTH-1:0] sign_flip;
  logic [DATA_WIDTH-1:0] old_cmp;
  logic [DATA_WIDTH-1:0] opd_cmp;
  logic                  opd_lt_old;
  logic                  old_lt_opd;

  // flip the sign bit so signed compare becomes unsigned compare
  assign sign_flip  = {is_signed_i, {(DATA_WIDTH-1){1'b0}}};
  assign old_cmp    = old_i ^ sign_flip;
  assign opd_cmp    = operand_i ^ sign_flip;
  assign opd_lt_old = opd_cmp < old_cmp;
  assign old_lt_opd = old_cmp < opd_cmp;

  always_comb begin
    case (op_i)
      OP_ADD:  result_o = old_i + operand_i;
      OP_SUB:  result_o = old_i - operand_i;
      OP_MUL:  result_o = DATA_WIDTH'(old_i * operand_i);
      OP_MIN:  result_o = opd_lt_old ? operand_i : old_i;
      OP_MAX:  result_o = old_lt_opd ? operand_i : old_i;
      default: result_o = old_i;
    endcase
  end

endmodule

FILE: test/msrt_checker.sv
// Scoreboard for the masked scatter-reduce table: watches the item, result and
// register-write ports, keeps its own copy of the table and checks each result.
// Depends on msrt_pkg for the op, status, kind and register codes.
module msrt_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // tdata: address[9:0], address_masked[10], value[42:11], value_masked[43], zero pad
  input  logic [msrt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind[0]
  input  logic                            s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // tdata: entry_value[31:0], entry_mask[32], zero pad
  input  logic [msrt_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  // tuser: status[1:0]
  input  logic [1:0]                      m_axis_tuser_i,
  input  logic                            cfg_we_i,
  input  logic [msrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msrt_pkg::CFG_W-1:0]      cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o,
  output int unsigned                     applied_o
);
  import msrt_pkg::*;

  typedef struct {
    status_e               status;
    logic [DATA_WIDTH-1:0] value;
    logic                  mask;
  } table_reply_t;

  logic [DATA_WIDTH-1:0] elem_mem [DEPTH];
  logic                  mask_mem [DEPTH];
  op_e                   op_q;
  logic                  signed_q;
  logic [TSIZE_W-1:0]    size_q;
  table_reply_t          replies_due [$];

  function automatic logic lower(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    return signed_q ? ($signed(a) < $signed(b)) : (a < b);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] combine(logic [DATA_WIDTH-1:0] cur,
                                                    logic [DATA_WIDTH-1:0] opd);
    case (op_q)
      OP_ADD:  return cur + opd;
      OP_SUB:  return cur - opd;
      OP_MUL:  return cur * opd;
      OP_MIN:  return lower(opd, cur) ? opd : cur;
      OP_MAX:  return lower(cur, opd) ? opd : cur;
      default: return cur;
    endcase
  endfunction

  // Apply one item to the local table and return the result it must produce.
  function automatic table_reply_t scatter_step(kind_e kind, logic [ADDR_W-1:0] addr,
                                                logic amask, logic [VAL_W-1:0] val,
                                                logic vmask);
    table_reply_t r;
    logic         in_rng;
    in_rng = ({1'b0, addr} < size_q);
    if (kind == KIND_READ) begin
      r.status = in_rng ? ST_READ : ST_OOR;
    end else if (op_q == OP_STORE) begin
      if (amask) begin
        r.status = ST_SKIPPED;
      end else if (!in_rng) begin
        r.status = ST_OOR;
      end else begin
        // a masked value only marks the entry, the old data stays
        if (vmask) begin
          mask_mem[addr] = 1'b1;
        end else begin
          elem_mem[addr] = val;
          mask_mem[addr] = 1'b0;
        end
        r.status = ST_APPLIED;
      end
    end else begin
      if (amask || vmask) begin
        r.status = ST_SKIPPED;
      end else if (!in_rng) begin
        r.status = ST_OOR;
      end else if (mask_mem[addr]) begin
        r.status = ST_SKIPPED;
      end else begin
        elem_mem[addr] = combine(elem_mem[addr], val);
        r.status = ST_APPLIED;
      end
    end
    r.value = in_rng ? elem_mem[addr] : '0;
    r.mask  = in_rng ? mask_mem[addr] : 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t got;
    table_reply_t due;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        elem_mem[i] = '0;
        mask_mem[i] = 1'b0;
      end
      op_q         = OP_ADD;
      signed_q     = 1'b1;
      size_q       = TSIZE_W'(1024);
      replies_due  = {};
      fail_count_o = 0;
      checked_o    = 0;
      applied_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_OP_MODE:    op_q     = op_e'(cfg_data_i[2:0]);
          REG_IS_SIGNED:  signed_q = cfg_data_i[0];
          REG_TABLE_SIZE: size_q   = cfg_data_i[TSIZE_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never belongs to the item of the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = status_e'(m_axis_tuser_i);
        got.value  = m_axis_tdata_i[DATA_WIDTH-1:0];
        got.mask   = m_axis_tdata_i[DATA_WIDTH];
        if (replies_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result status %0d value %h mask %b",
                     $realtime, got.status, got.value, got.mask);
        end else begin
          due = replies_due.pop_front();
          checked_o++;
          if (got.status != due.status || got.value != due.value || got.mask != due.mask) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected status %0d value %h mask %b, got %0d %h %b",
                       $realtime, due.status, due.value, due.mask,
                       got.status, got.value, got.mask);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due = scatter_step(kind_e'(s_axis_tuser_i), s_axis_tdata_i[9:0], s_axis_tdata_i[10],
                           s_axis_tdata_i[42:11], s_axis_tdata_i[43]);
        if (due.status == ST_APPLIED) applied_o++;
        replies_due.push_back(due);
      end
    end
    pending_o = replies_due.size();
  end

endmodule

FILE: test/masked_scatter_reduce_table_unit_tb.sv
// Testbench top for masked_scatter_reduce_table_unit: clock, reset, item and
// register stimulus, flow control and verdict. Depends on msrt_pkg and msrt_checker.
module masked_scatter_reduce_table_unit_tb;
  import msrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // tdata: address[9:0], address_masked[10], value[42:11], value_masked[43], zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  // tuser: kind[0]
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // tdata: entry_value[31:0], entry_mask[32], zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // tuser: status[1:0]
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned applied;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent;
  logic [TSIZE_W-1:0] cur_size;

  masked_scatter_reduce_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  msrt_checker table_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .applied_o       (applied)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stalls at random, one decision per cycle
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(kind_e kind, logic [ADDR_W-1:0] addr, logic amask,
                           logic [VAL_W-1:0] val, logic vmask);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, vmask, val, amask, addr};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    sent++;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(op_e op, logic sgn, logic [TSIZE_W-1:0] size);
    drain();
    write_reg(REG_OP_MODE, CFG_W'(op));
    write_reg(REG_IS_SIGNED, CFG_W'(sgn));
    write_reg(REG_TABLE_SIZE, CFG_W'(size));
    cur_size = size;
  endtask

  task automatic random_mode();
    op_e                op;
    logic [TSIZE_W-1:0] size;
    int unsigned        sel;
    op  = ($urandom_range(3) == 0) ? OP_STORE : op_e'($urandom_range(7));
    sel = $urandom_range(11);
    case (sel)
      6:       size = TSIZE_W'($urandom_range(1, 1024));
      7:       size = TSIZE_W'($urandom_range(1, 16));
      8:       size = ($urandom_range(1) == 0) ? '0 : TSIZE_W'(2047);
      9:       size = TSIZE_W'($urandom_range(1025, 2047));
      10:      size = TSIZE_W'(1);
      default: size = TSIZE_W'(1024);
    endcase
    set_mode(op, 1'($urandom_range(1)), size);
  endtask

  task automatic random_item();
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
    int unsigned       sel;
    kind = ($urandom_range(99) < 15) ? KIND_READ : KIND_UPDATE;
    sel  = $urandom_range(9);
    // hot addresses make repeated updates hit the forwarding path
    if (sel < 5)       addr = ADDR_W'($urandom_range(15));
    else if (sel == 5) addr = ADDR_W'(1023 - $urandom_range(3));
    else if (sel == 6) addr = ADDR_W'(cur_size - $urandom_range(1));
    else               addr = ADDR_W'($urandom);
    sel = $urandom_range(9);
    case (sel)
      0:       val = '0;
      1:       val = 32'hFFFF_FFFF;
      2:       val = 32'h8000_0000;
      3:       val = 32'h7FFF_FFFF;
      4, 5:    val = VAL_W'($urandom_range(15));
      default: val = $urandom;
    endcase
    send_item(kind, addr, $urandom_range(99) < 8, val, $urandom_range(99) < 12);
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_OP_MODE;
    cfg_data_i      = '0;
    cycles          = 0;
    sent            = 0;
    send_idle_pct   = 9;
    recv_idle_pct   = 77;
    cur_size        = TSIZE_W'(1024);
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset defaults are add, signed, full table
    send_item(KIND_READ, 10'd0, 1'b0, '0, 1'b0);
    send_item(KIND_READ, 10'd5, 1'b1, 32'hDEAD_BEEF, 1'b1);
    send_item(KIND_UPDATE, 10'd1023, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_UPDATE, 10'd1023, 1'b0, 32'd2, 1'b0);
    send_item(KIND_UPDATE, 10'd5, 1'b1, 32'd3, 1'b0);
    send_item(KIND_UPDATE, 10'd5, 1'b0, 32'd3, 1'b1);
    set_mode(OP_SUB, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd7, 1'b0, 32'd1, 1'b0);
    set_mode(OP_MUL, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd1023, 1'b0, 32'h8000_0000, 1'b0);
    send_item(KIND_UPDATE, 10'd1023, 1'b0, 32'd2, 1'b0);
    set_mode(OP_MIN, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd7, 1'b0, 32'h8000_0000, 1'b0);
    set_mode(OP_MAX, 1'b0, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd7, 1'b0, 32'h7FFF_FFFF, 1'b0);
    set_mode(OP_MIN, 1'b0, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd7, 1'b0, 32'h7FFF_FFFF, 1'b0);
    // masked value under store marks the entry, later reduces skip it
    set_mode(OP_STORE, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd9, 1'b0, 32'd0, 1'b1);
    send_item(KIND_UPDATE, 10'd9, 1'b1, 32'd5, 1'b0);
    set_mode(OP_ADD, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd9, 1'b0, 32'd1, 1'b0);
    set_mode(OP_STORE, 1'b0, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd9, 1'b0, 32'h1234, 1'b0);
    set_mode(OP_NOP6, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd9, 1'b0, 32'd77, 1'b0);
    set_mode(OP_NOP7, 1'b1, TSIZE_W'(1024));
    send_item(KIND_UPDATE, 10'd9, 1'b0, 32'd77, 1'b1);
    // empty table: a read is out of range, a masked update is skipped
    set_mode(OP_ADD, 1'b1, '0);
    send_item(KIND_READ, 10'd0, 1'b0, '0, 1'b0);
    send_item(KIND_UPDATE, 10'd0, 1'b1, 32'd1, 1'b0);
    set_mode(OP_ADD, 1'b1, TSIZE_W'(1));
    send_item(KIND_UPDATE, 10'd0, 1'b0, 32'd5, 1'b0);
    send_item(KIND_UPDATE, 10'd1, 1'b0, 32'd5, 1'b0);
    set_mode(OP_STORE, 1'b1, TSIZE_W'(2047));
    send_item(KIND_UPDATE, 10'd1023, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_READ, 10'd1023, 1'b0, '0, 1'b0);

    // random: three flow-control profiles, each split into register settings
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 9 : (p == 1) ? 77 : 0;
      recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 9 : 0;
      phase_start   = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        random_mode();
        repeat ($urandom_range(30, 70)) random_item();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("summary: %0d items sent, %0d results checked, %0d updates applied", sent,
             checked, applied);
    $display("summary: ops 0-7, signed and unsigned compare, table sizes 0 to 2047");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
